[rtl/torque_discrepancy_collision_check_top_assert.svh]
// Assertion macros for the torque discrepancy collision check.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef TORQUE_DISCREPANCY_COLLISION_CHECK_TOP_ASSERT_SVH
`define TORQUE_DISCREPANCY_COLLISION_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define TDCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tdcc check failed");

// next-cycle implication
`define TDCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdcc check failed");

`endif

[rtl/tdcc_pkg.sv]
// Shared constants and types for the torque discrepancy collision check.
// No dependencies.
`default_nettype none

package tdcc_pkg;

  localparam int NJ          = 3;
  localparam int LANES_DEF   = 3;
  localparam int MAX_WIN_DEF = 16;
  localparam int TORQUE_DEF  = 16;

  localparam int THR_W     = 17;
  localparam int OFS_W     = 16;
  localparam int EXTRA_W   = 4;
  localparam int WIN_W     = EXTRA_W + 1;
  localparam int DISC_W    = 18;
  localparam int SUM_W     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = THR_W;

  localparam logic signed [1:0] SGN_ZERO = 2'sb00;
  localparam logic signed [1:0] SGN_POS  = 2'sb01;
  localparam logic signed [1:0] SGN_NEG  = 2'sb11;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR0  = 3'd0,
    REG_THR1  = 3'd1,
    REG_THR2  = 3'd2,
    REG_OFS0  = 3'd3,
    REG_OFS1  = 3'd4,
    REG_OFS2  = 3'd5,
    REG_EXTRA = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic adv;
    logic clr;
  } lane_ctl_t;

endpackage

`default_nettype wire

[rtl/tdcc_lane.sv]
// One joint lane: discrepancy and sign stage, then sign ring and running sum.
// Depends on tdcc_pkg.
`default_nettype none

module tdcc_lane #(
  parameter int MAX_WINDOW  = tdcc_pkg::MAX_WIN_DEF,
  parameter int TORQUE_BITS = tdcc_pkg::TORQUE_DEF,
  parameter int POS_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  tdcc_pkg::lane_ctl_t                   ctl_i,
  input  wire  signed [TORQUE_BITS-1:0]         target_i,
  input  wire  signed [TORQUE_BITS-1:0]         measured_i,
  input  wire  signed [tdcc_pkg::OFS_W-1:0]     offset_i,
  input  wire         [tdcc_pkg::THR_W-1:0]     threshold_i,
  input  wire         [POS_W-1:0]               pos_i,
  input  wire         [tdcc_pkg::WIN_W-1:0]     win_i,
  output logic        [tdcc_pkg::DISC_W-1:0]    disc_o,
  output logic                                  ok_o
);
  import tdcc_pkg::*;

  localparam int DW = ((TORQUE_BITS > OFS_W) ? TORQUE_BITS : OFS_W) + 2;

  logic signed [DW-1:0] tgt_x, meas_x, ofs_x, diff;
  logic        [DW-1:0] mag;
  logic                 fail;
  logic signed [1:0]    sgn_d;

  logic [DISC_W-1:0]    disc_q;
  logic signed [1:0]    sgn_q;

  logic signed [1:0]       hist_q [MAX_WINDOW];
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic        [SUM_W-1:0] sum_abs;
  logic signed [1:0]       cur;

  always_comb begin
    tgt_x  = DW'(target_i);
    meas_x = DW'(measured_i);
    ofs_x  = DW'(offset_i);
    diff   = tgt_x - (meas_x + ofs_x);
    mag    = diff[DW-1] ? DW'(-diff) : DW'(diff);
    fail   = !(mag < DW'(threshold_i));
    if (fail && diff > 0) begin
      sgn_d = SGN_POS;
    end else if (fail && diff < 0) begin
      sgn_d = SGN_NEG;
    end else begin
      sgn_d = SGN_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      disc_q <= diff[DISC_W-1:0];
      sgn_q  <= sgn_d;
    end
  end

  always_comb begin
    cur     = hist_q[pos_i];
    sum_d   = sum_q + SUM_W'(sgn_q) - SUM_W'(cur);
    sum_abs = sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);
    ok_o    = sum_abs < SUM_W'(win_i);
    disc_o  = disc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) hist_q[i] <= SGN_ZERO;
    end else if (ctl_i.clr) begin
      sum_q <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) hist_q[i] <= SGN_ZERO;
    end else if (ctl_i.adv) begin
      sum_q          <= sum_d;
      hist_q[pos_i]  <= sgn_q;
    end
  end

endmodule

`default_nettype wire

[rtl/tdcc_merge.sv]
// Merge and output register: combines lane verdicts into mask and all-valid.
// Depends on tdcc_pkg.
`default_nettype none

module tdcc_merge #(
  parameter int LANES = tdcc_pkg::LANES_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               load_i,
  input  wire                               out_ready_i,
  input  wire  [tdcc_pkg::DISC_W-1:0]       disc_i [tdcc_pkg::NJ],
  input  wire  [tdcc_pkg::NJ-1:0]           ok_i,
  output logic                              out_valid_o,
  output logic [tdcc_pkg::DISC_W-1:0]       disc_o [tdcc_pkg::NJ],
  output logic [tdcc_pkg::NJ-1:0]           mask_o,
  output logic                              all_o
);
  import tdcc_pkg::*;

  logic [NJ-1:0] lane_en;
  logic          valid_q, valid_d;

  always_comb begin
    for (int j = 0; j < NJ; j++) lane_en[j] = (j < LANES);
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      disc_o <= disc_i;
      mask_o <= ok_i & lane_en;
      all_o  <= &(ok_i | ~lane_en);
    end
  end

  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

[rtl/torque_discrepancy_collision_check_top.sv]
// Channel  | handshake              | payload
// in       | in_valid_i/in_ready_o   | in_command_i, in_target_joint*_i, in_measured_joint*_i
// out      | out_valid_o/out_ready_i | out_discrepancy_joint*_o, out_valid_mask_o, out_all_valid_o
// cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// One item per cycle while results are taken. A sample's result is registered in stages:
// stage one forms discrepancy and sign per lane, stage two updates the sign ring and running
// sum and loads the output register once the output is free. A clear item gives no result.
// While a result waits, stage one takes items until it holds a sample, then the input stalls
// until the output is taken. Reset clears history, sums, ring position, offsets, extra and valid
// flags and sets thresholds to all ones. Top level of the torque discrepancy collision check;
// uses tdcc_pkg, tdcc_lane, tdcc_merge and the assertion macro header.
`default_nettype none
`include "torque_discrepancy_collision_check_top_assert.svh"

module torque_discrepancy_collision_check_top #(
  parameter int LANES       = tdcc_pkg::LANES_DEF,
  parameter int MAX_WINDOW  = tdcc_pkg::MAX_WIN_DEF,
  parameter int TORQUE_BITS = tdcc_pkg::TORQUE_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire                                  in_command_i,
  input  wire  signed [TORQUE_BITS-1:0]        in_target_joint0_i,
  input  wire  signed [TORQUE_BITS-1:0]        in_target_joint1_i,
  input  wire  signed [TORQUE_BITS-1:0]        in_target_joint2_i,
  input  wire  signed [TORQUE_BITS-1:0]        in_measured_joint0_i,
  input  wire  signed [TORQUE_BITS-1:0]        in_measured_joint1_i,
  input  wire  signed [TORQUE_BITS-1:0]        in_measured_joint2_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic signed [tdcc_pkg::DISC_W-1:0]   out_discrepancy_joint0_o,
  output logic signed [tdcc_pkg::DISC_W-1:0]   out_discrepancy_joint1_o,
  output logic signed [tdcc_pkg::DISC_W-1:0]   out_discrepancy_joint2_o,
  output logic        [tdcc_pkg::NJ-1:0]       out_valid_mask_o,
  output logic                                 out_all_valid_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire         [tdcc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire         [tdcc_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import tdcc_pkg::*;

  localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [THR_W-1:0]        thr_q [NJ];
  logic signed [OFS_W-1:0] ofs_q [NJ];
  logic [EXTRA_W-1:0]      extra_q;
  logic [POS_W-1:0]        ring_q, pos_q;
  logic                    s1_valid_q, s1_clr_q;

  logic                    out_free, s1_adv, in_acc, cfg_acc, cfg_wr_extra;
  logic [WIN_W-1:0]        win_raw, win, ring_x, inc, pos_nx;
  lane_ctl_t               ctl;

  logic signed [TORQUE_BITS-1:0] tgt [NJ];
  logic signed [TORQUE_BITS-1:0] meas [NJ];
  logic [DISC_W-1:0]       lane_disc [NJ];
  logic [NJ-1:0]           lane_ok;
  logic [DISC_W-1:0]       out_disc [NJ];

  assign cfg_ready_o  = 1'b1;
  assign cfg_acc      = cfg_valid_i && cfg_ready_o;
  assign cfg_wr_extra = cfg_acc && (cfg_reg_e'(cfg_index_i) == REG_EXTRA);

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_adv     = s1_valid_q && (s1_clr_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    win_raw = WIN_W'(extra_q) + WIN_W'(1);
    win     = (int'(win_raw) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : win_raw;
    ring_x  = WIN_W'(ring_q);
    inc     = ring_x + WIN_W'(1);
    pos_nx  = (inc == win) ? '0 : inc;
    ctl.load = in_acc && (in_command_i == CMD_SAMPLE);
    ctl.adv  = s1_adv && !s1_clr_q;
    ctl.clr  = (s1_adv && s1_clr_q) || cfg_wr_extra;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NJ; j++) begin
        thr_q[j] <= '1;
        ofs_q[j] <= '0;
      end
      extra_q <= '0;
    end else if (cfg_acc) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_THR0:  thr_q[0] <= cfg_data_i[THR_W-1:0];
        REG_THR1:  thr_q[1] <= cfg_data_i[THR_W-1:0];
        REG_THR2:  thr_q[2] <= cfg_data_i[THR_W-1:0];
        REG_OFS0:  ofs_q[0] <= cfg_data_i[OFS_W-1:0];
        REG_OFS1:  ofs_q[1] <= cfg_data_i[OFS_W-1:0];
        REG_OFS2:  ofs_q[2] <= cfg_data_i[OFS_W-1:0];
        REG_EXTRA: extra_q  <= cfg_data_i[EXTRA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q     <= '0;
      s1_valid_q <= 1'b0;
      s1_clr_q   <= 1'b0;
    end else begin
      if (cfg_wr_extra || (in_acc && in_command_i == CMD_CLEAR)) begin
        ring_q <= '0;
      end else if (in_acc) begin
        ring_q <= POS_W'(pos_nx);
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_clr_q   <= in_command_i;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q <= POS_W'(pos_nx);
    end
  end

  assign tgt[0]  = in_target_joint0_i;
  assign tgt[1]  = in_target_joint1_i;
  assign tgt[2]  = in_target_joint2_i;
  assign meas[0] = in_measured_joint0_i;
  assign meas[1] = in_measured_joint1_i;
  assign meas[2] = in_measured_joint2_i;

  for (genvar j = 0; j < NJ; j++) begin : g_lane
    if (j < LANES) begin : g_on
      tdcc_lane #(
        .MAX_WINDOW (MAX_WINDOW),
        .TORQUE_BITS(TORQUE_BITS),
        .POS_W      (POS_W)
      ) u_lane (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .target_i   (tgt[j]),
        .measured_i (meas[j]),
        .offset_i   (ofs_q[j]),
        .threshold_i(thr_q[j]),
        .pos_i      (pos_q),
        .win_i      (win),
        .disc_o     (lane_disc[j]),
        .ok_o       (lane_ok[j])
      );
    end else begin : g_off
      assign lane_disc[j] = '0;
      assign lane_ok[j]   = 1'b1;
    end
  end

  tdcc_merge #(
    .LANES(LANES)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (ctl.adv),
    .out_ready_i(out_ready_i),
    .disc_i     (lane_disc),
    .ok_i       (lane_ok),
    .out_valid_o(out_valid_o),
    .disc_o     (out_disc),
    .mask_o     (out_valid_mask_o),
    .all_o      (out_all_valid_o)
  );

  assign out_discrepancy_joint0_o = out_disc[0];
  assign out_discrepancy_joint1_o = out_disc[1];
  assign out_discrepancy_joint2_o = out_disc[2];

  `TDCC_ASSERT_NOW(a_ring_in_window, 1'b1, WIN_W'(ring_q) < win)
  `TDCC_ASSERT_NEXT(a_clear_resets_ring, in_acc && in_command_i == CMD_CLEAR, ring_q == '0)
  `TDCC_ASSERT_NEXT(a_sample_reaches_out, ctl.adv, out_valid_o)

endmodule

`default_nettype wire

[sim/tb_torque_discrepancy_collision_check_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for torque_discrepancy_collision_check_top: a directed table, then
// random config phases with shaped sign runs; each result is checked against its table
// value or a local predictor. Depends on tdcc_pkg and the top-level RTL only.

module tb_torque_discrepancy_collision_check_top;
  import tdcc_pkg::*;

  localparam int TQ_W          = 16;
  localparam int WIN_MAX       = 16;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 5000;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 104;

  // targets 0..2, then measurements 0..2
  typedef logic [5:0][TQ_W-1:0] torque_set_t;

  typedef struct packed {
    logic [DISC_W-1:0] disc0;
    logic [DISC_W-1:0] disc1;
    logic [DISC_W-1:0] disc2;
    logic [NJ-1:0]     mask;
    logic              all_ok;
  } verdict_t;

  typedef enum logic {STEP_CFG, STEP_ITEM} step_kind_e;

  typedef struct packed {
    step_kind_e            kind;
    cfg_reg_e              reg_idx;
    logic [CFG_DAT_W-1:0]  data;
    logic                  cmd;
    torque_set_t           torq;
    logic                  typed;
    verdict_t              want;
  } plan_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    in_command_i = CMD_SAMPLE;
  logic signed [TQ_W-1:0]  in_target_joint0_i = '0;
  logic signed [TQ_W-1:0]  in_target_joint1_i = '0;
  logic signed [TQ_W-1:0]  in_target_joint2_i = '0;
  logic signed [TQ_W-1:0]  in_measured_joint0_i = '0;
  logic signed [TQ_W-1:0]  in_measured_joint1_i = '0;
  logic signed [TQ_W-1:0]  in_measured_joint2_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DISC_W-1:0] out_discrepancy_joint0_o;
  logic signed [DISC_W-1:0] out_discrepancy_joint1_o;
  logic signed [DISC_W-1:0] out_discrepancy_joint2_o;
  logic [NJ-1:0]           out_valid_mask_o;
  logic                    out_all_valid_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]    cfg_data_i = '0;

  logic [THR_W-1:0]  limit_q [NJ];
  int                offset_q [NJ];
  int                extra_q;
  logic signed [1:0] sign_ring [NJ][WIN_MAX];
  int                sign_sum [NJ];
  int                ring_slot;

  verdict_t pending_verdicts [$];
  verdict_t oldest;
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       stall_left = 0;
  int       run_sign [NJ];
  logic     tx_quiet = 1'b1;
  logic     rx_quiet = 1'b1;

  torque_discrepancy_collision_check_top uut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .in_command_i             (in_command_i),
    .in_target_joint0_i       (in_target_joint0_i),
    .in_target_joint1_i       (in_target_joint1_i),
    .in_target_joint2_i       (in_target_joint2_i),
    .in_measured_joint0_i     (in_measured_joint0_i),
    .in_measured_joint1_i     (in_measured_joint1_i),
    .in_measured_joint2_i     (in_measured_joint2_i),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .out_discrepancy_joint0_o (out_discrepancy_joint0_o),
    .out_discrepancy_joint1_o (out_discrepancy_joint1_o),
    .out_discrepancy_joint2_o (out_discrepancy_joint2_o),
    .out_valid_mask_o         (out_valid_mask_o),
    .out_all_valid_o          (out_all_valid_o),
    .cfg_valid_i              (cfg_valid_i),
    .cfg_ready_o              (cfg_ready_o),
    .cfg_index_i              (cfg_index_i),
    .cfg_data_i               (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic int pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void wipe_history();
    for (int j = 0; j < NJ; j++) begin
      for (int k = 0; k < WIN_MAX; k++) sign_ring[j][k] = SGN_ZERO;
      sign_sum[j] = 0;
    end
    ring_slot = 0;
  endfunction

  function automatic void apply_cfg(cfg_reg_e r, logic [CFG_DAT_W-1:0] v);
    case (r)
      REG_THR0, REG_THR1, REG_THR2: limit_q[int'(r) - int'(REG_THR0)] = v[THR_W-1:0];
      REG_OFS0, REG_OFS1, REG_OFS2:
        offset_q[int'(r) - int'(REG_OFS0)] = int'($signed(v[OFS_W-1:0]));
      REG_EXTRA: begin
        extra_q = int'(v[EXTRA_W-1:0]);
        wipe_history();
      end
      default: ;
    endcase
  endfunction

  // Advances the sign ring by one sample and returns the verdict it yields.
  function automatic verdict_t judge_sample(torque_set_t tq);
    int                w;
    int                d;
    int                mag;
    int                disc [NJ];
    logic signed [1:0] sg;
    verdict_t          v;
    w = extra_q + 1;
    if (w > WIN_MAX) w = WIN_MAX;
    ring_slot = (ring_slot + 1) % w;
    v = '0;
    for (int j = 0; j < NJ; j++) begin
      d = int'($signed(tq[j])) - (int'($signed(tq[NJ+j])) + offset_q[j]);
      disc[j] = d;
      mag = (d < 0) ? -d : d;
      sg = SGN_ZERO;
      if (mag >= int'(limit_q[j])) sg = (d > 0) ? SGN_POS : ((d < 0) ? SGN_NEG : SGN_ZERO);
      sign_sum[j] += int'(sg) - int'(sign_ring[j][ring_slot]);
      sign_ring[j][ring_slot] = sg;
      if (((sign_sum[j] < 0) ? -sign_sum[j] : sign_sum[j]) < w) v.mask[j] = 1'b1;
    end
    v.disc0 = disc[0][DISC_W-1:0];
    v.disc1 = disc[1][DISC_W-1:0];
    v.disc2 = disc[2][DISC_W-1:0];
    v.all_ok = &v.mask;
    return v;
  endfunction

  function automatic plan_row_t cfg_step(cfg_reg_e r, int v);
    plan_row_t p;
    p = '0;
    p.kind = STEP_CFG;
    p.reg_idx = r;
    p.data = v[CFG_DAT_W-1:0];
    return p;
  endfunction

  function automatic plan_row_t sample_step(logic cmd, int t0, int t1, int t2,
                                            int m0, int m1, int m2);
    plan_row_t p;
    p = '0;
    p.kind = STEP_ITEM;
    p.cmd = cmd;
    p.torq[0] = t0[TQ_W-1:0];
    p.torq[1] = t1[TQ_W-1:0];
    p.torq[2] = t2[TQ_W-1:0];
    p.torq[3] = m0[TQ_W-1:0];
    p.torq[4] = m1[TQ_W-1:0];
    p.torq[5] = m2[TQ_W-1:0];
    return p;
  endfunction

  function automatic plan_row_t checked_step(int t0, int t1, int t2, int m0, int m1, int m2,
                                             int d0, int d1, int d2, logic [NJ-1:0] mask);
    plan_row_t p;
    p = sample_step(CMD_SAMPLE, t0, t1, t2, m0, m1, m2);
    p.typed = 1'b1;
    p.want.disc0 = d0[DISC_W-1:0];
    p.want.disc1 = d1[DISC_W-1:0];
    p.want.disc2 = d2[DISC_W-1:0];
    p.want.mask = mask;
    p.want.all_ok = &mask;
    return p;
  endfunction

  task automatic send_item(logic cmd, torque_set_t tq, logic typed, verdict_t want);
    int       gap;
    verdict_t v;
    gap = tx_quiet ? 0 : pick_delay();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_command_i <= cmd;
    in_target_joint0_i <= tq[0];
    in_target_joint1_i <= tq[1];
    in_target_joint2_i <= tq[2];
    in_measured_joint0_i <= tq[3];
    in_measured_joint1_i <= tq[4];
    in_measured_joint2_i <= tq[5];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (cmd == CMD_CLEAR) begin
      wipe_history();
    end else begin
      v = judge_sample(tq);
      if (typed) v = want;
      pending_verdicts = {pending_verdicts, v};
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_DAT_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_cfg(r, v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int n_items);
    int          r;
    int          v;
    int          d;
    int          m;
    int          t;
    int          s;
    int          thr;
    logic [31:0] bits;
    torque_set_t tq;
    settle();
    for (int j = 0; j < NJ; j++) begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = 131071;
        default: v = $urandom_range(0, 3000);
      endcase
      write_reg(cfg_reg_e'(int'(REG_THR0) + j), v[CFG_DAT_W-1:0]);
    end
    for (int j = 0; j < NJ; j++) begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        default: v = int'($urandom_range(0, 2000)) - 1000;
      endcase
      bits = $urandom();
      write_reg(cfg_reg_e'(int'(REG_OFS0) + j), {bits[0], v[OFS_W-1:0]});
    end
    case ($urandom_range(0, 2))
      0: v = 0;
      1: v = 15;
      default: v = $urandom_range(1, 14);
    endcase
    bits = $urandom();
    write_reg(REG_EXTRA, {bits[CFG_DAT_W-EXTRA_W-1:0], v[EXTRA_W-1:0]});
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);

    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 199) == 0) settle();
      r = $urandom_range(0, 99);
      tq = {$urandom(), $urandom(), $urandom()};
      if (r < 3) begin
        send_item(CMD_CLEAR, tq, 1'b0, '0);
      end else if (r < 20) begin
        send_item(CMD_SAMPLE, tq, 1'b0, '0);
      end else begin
        // same-sign failure runs, occasionally broken
        for (int j = 0; j < NJ; j++) begin
          if ($urandom_range(0, 39) == 0) run_sign[j] = int'($urandom_range(0, 2)) - 1;
          s = run_sign[j];
          if ($urandom_range(0, 29) == 0) s = -s;
          m = int'($urandom_range(0, 16000)) - 8000;
          thr = int'(limit_q[j]);
          if (s == 0) begin
            d = (thr > 0) ? int'($urandom_range(0, (thr > 3000) ? 3000 : thr - 1)) : 0;
            if ($urandom_range(0, 1) != 0) d = -d;
          end else begin
            d = s * (thr + int'($urandom_range(0, 40)));
          end
          t = m + offset_q[j] + d;
          if (t > 32767) t = 32767;
          else if (t < -32768) t = -32768;
          tq[j] = t[TQ_W-1:0];
          tq[NJ+j] = m[TQ_W-1:0];
        end
        send_item(CMD_SAMPLE, tq, 1'b0, '0);
      end
    end
  endtask

  task automatic check_field(string name, logic signed [31:0] e, logic signed [31:0] a);
    if (e !== a) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_quiet) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ready_i <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b0;
      stall_left <= pick_delay();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: result with no item waiting for it", $time);
      end else begin
        oldest = pending_verdicts.pop_front();
        check_field("discrepancy_joint0", $signed(oldest.disc0), out_discrepancy_joint0_o);
        check_field("discrepancy_joint1", $signed(oldest.disc1), out_discrepancy_joint1_o);
        check_field("discrepancy_joint2", $signed(oldest.disc2), out_discrepancy_joint2_o);
        check_field("valid_mask", {29'd0, oldest.mask}, {29'd0, out_valid_mask_o});
        check_field("all_valid", {31'd0, oldest.all_ok}, {31'd0, out_all_valid_o});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_torque_discrepancy_collision_check_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    plan_row_t plan [$];
    logic      last_item;
    for (int j = 0; j < NJ; j++) begin
      limit_q[j] = 17'h1FFFF;
      offset_q[j] = 0;
      run_sign[j] = 0;
    end
    extra_q = 0;
    wipe_history();

    plan = {plan, checked_step(0, 0, 0, 0, 0, 0, 0, 0, 0, 3'b111)};
    plan = {plan, checked_step(32767, 32767, 32767, -32768, -32768, -32768,
                               65535, 65535, 65535, 3'b111)};
    plan = {plan, checked_step(-32768, -32768, -32768, 32767, 32767, 32767,
                               -65535, -65535, -65535, 3'b111)};
    plan = {plan, cfg_step(REG_OFS0, 32767)};
    plan = {plan, cfg_step(REG_OFS1, -32768)};
    plan = {plan, cfg_step(REG_OFS2, 1)};
    plan = {plan, checked_step(-32768, 32767, 0, 32767, -32768, 0,
                               -98302, 98303, -1, 3'b111)};
    plan = {plan, cfg_step(REG_THR0, 0)};
    plan = {plan, cfg_step(REG_THR1, 0)};
    plan = {plan, cfg_step(REG_THR2, 0)};
    plan = {plan, cfg_step(REG_OFS0, 0)};
    plan = {plan, cfg_step(REG_OFS1, 0)};
    plan = {plan, cfg_step(REG_OFS2, 0)};
    // zero discrepancy fails at threshold zero but never flags
    plan = {plan, checked_step(5, 1, -1, 5, 0, 0, 0, 1, -1, 3'b001)};
    plan = {plan, cfg_step(REG_EXTRA, 2)};
    plan = {plan, cfg_step(REG_THR0, 100)};
    plan = {plan, cfg_step(REG_THR1, 100)};
    plan = {plan, cfg_step(REG_THR2, 100)};
    plan = {plan, sample_step(CMD_SAMPLE, 100, -100, 99, 0, 0, 0)};
    plan = {plan, sample_step(CMD_SAMPLE, 100, -100, 99, 0, 0, 0)};
    plan = {plan, checked_step(100, -100, 99, 0, 0, 0, 100, -100, 99, 3'b100)};
    plan = {plan, sample_step(CMD_CLEAR, 7, -7, 7, -7, 7, -7)};
    plan = {plan, checked_step(100, -100, 99, 0, 0, 0, 100, -100, 99, 3'b111)};
    plan = {plan, sample_step(CMD_SAMPLE, 100, 100, -101, 0, 0, 0)};
    plan = {plan, sample_step(CMD_SAMPLE, -3, 200, -150, 0, 0, 0)};
    plan = {plan, sample_step(CMD_SAMPLE, 32767, -32768, -32768, -32768, 32767, 32767)};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    last_item = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        if (last_item) settle();
        write_reg(plan[i].reg_idx, plan[i].data);
        last_item = 1'b0;
      end else begin
        send_item(plan[i].cmd, plan[i].torq, plan[i].typed, plan[i].want);
        last_item = 1'b1;
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) random_phase(PHASE_ITEMS);

    settle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("tb_torque_discrepancy_collision_check_top passed");
    end else begin
      $display("tb_torque_discrepancy_collision_check_top failed");
    end
    $finish;
  end

endmodule

[torque_discrepancy_collision_check_top.f]
+incdir+rtl
rtl/tdcc_pkg.sv
rtl/tdcc_lane.sv
rtl/tdcc_merge.sv
rtl/torque_discrepancy_collision_check_top.sv
sim/tb_torque_discrepancy_collision_check_top.sv
